// File: rtl/core/hufd_pkg.sv
package hufd_pkg;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  symbol;
    logic [31:0] frequency;
    logic [7:0]  code_byte;
    logic [3:0]  valid_bits;
  } item_t;

  typedef struct packed {
    logic [7:0] decoded_symbol;
    logic [1:0] status;
    logic       last;
  } result_t;

  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_BUILD  = 2'd1;
  localparam logic [1:0] KIND_DECODE = 2'd2;

  localparam logic [1:0] ST_SYMBOL     = 2'd0;
  localparam logic [1:0] ST_BUILT      = 2'd1;
  localparam logic [1:0] ST_BUILD_FAIL = 2'd2;
  localparam logic [1:0] ST_NO_TREE    = 2'd3;

  localparam logic [3:0] MAX_BITS = 4'd8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PASS,
    S_MRD,
    S_MPICK,
    S_DEC,
    S_DUSE
  } state_e;

endpackage

// File: rtl/core/hufd_ram.sv
module hufd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/huffman_tree_build_and_decode.sv
// Huffman tree builder and decoder.
// Commands enter on item_i, taken when start is high and busy is low.
//   Load (kind 0): writes one symbol frequency, no result.
//   Build (kind 1): sorts the nonzero frequencies by repeated scans of the
//     frequency memory, one scan per leaf plus one more scan that finds
//     nothing, then merges with two queues. One result: built or all zero.
//   Decode (kind 2): walks one tree edge per code bit through the child
//     memory; a single-leaf tree skips the child read. Zero to eight
//     symbol results; the last is flagged.
//     Without a tree one result with status no-tree.
// Results are registered and appear on result_o for one cycle marked by
// result_valid_o, in the cycle after they are formed; the receiver cannot stall.
// Reset clears all frequencies (per-entry valid bits) and drops the tree.
module huffman_tree_build_and_decode #(
  parameter int SYMBOLS   = 256,
  parameter int FREQ_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  hufd_pkg::item_t   item_i,
  output logic             result_valid_o,
  output hufd_pkg::result_t result_o
);

  localparam int IW = $clog2(SYMBOLS);
  localparam int CW = IW + 1;
  localparam int NW = $clog2(2 * SYMBOLS);
  localparam int WW = FREQ_BITS + 8;
  localparam int AW = IW + FREQ_BITS;
  localparam logic [NW-1:0] SYM_N = NW'(SYMBOLS);
  localparam logic [CW-1:0] SYM_C = CW'(SYMBOLS);

  hufd_pkg::state_e state_q, state_d;

  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 rv_q, rv_d;
  logic [IW-1:0]        rsym_q, rsym_d;
  logic                 have_prev_q, have_prev_d;
  logic [FREQ_BITS-1:0] pf_q, pf_d;
  logic [IW-1:0]        ps_q, ps_d;
  logic                 found_q, found_d;
  logic [FREQ_BITS-1:0] bf_q, bf_d;
  logic [IW-1:0]        bs_q, bs_d;
  logic [CW-1:0]        na_q, na_d, ha_q, ha_d, nb_q, nb_d, hb_q, hb_d;
  logic                 second_q, second_d;
  logic [NW-1:0]        n1_q, n1_d;
  logic [WW-1:0]        w1_q, w1_d;
  logic [NW-1:0]        root_q, root_d, walk_q, walk_d;
  logic                 ready_q, ready_d;
  logic [7:0]           byte_q, byte_d;
  logic [3:0]           bcnt_q, bcnt_d;
  logic                 pend_v_q, pend_v_d;
  logic [7:0]           pend_s_q, pend_s_d;
  logic                 res_v_q, res_v_d;
  hufd_pkg::result_t    res_q, res_d;
  logic [SYMBOLS-1:0]   fvld_q, fvld_d;
  logic                 fv_q;

  logic                 f_we;
  logic [IW-1:0]        f_ra;
  logic [FREQ_BITS-1:0] f_rd;
  logic                 a_we;
  logic [AW-1:0]        a_wd, a_rd;
  logic                 b_we;
  logic [WW-1:0]        b_wd, b_rd;
  logic                 c_we;
  logic [2*NW-1:0]      c_wd, c_rd;
  logic [IW-1:0]        c_ra;

  logic                 accept;
  logic                 sym_ok;
  logic [FREQ_BITS-1:0] fdat;
  logic                 cand;
  logic                 a_empty, b_empty, pick_a;
  logic [NW-1:0]        pick_n;
  logic [WW-1:0]        pick_w;
  logic [NW-1:0]        cur;
  logic                 root_leaf;
  logic [NW-1:0]        child;
  logic [NW-1:0]        leaf_n;
  logic                 leaf_hit;

  assign busy      = (state_q != hufd_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign sym_ok    = (32'(item_i.symbol) < SYMBOLS);
  assign fdat      = fv_q ? f_rd : '0;
  assign cand      = rv_q && (fdat != '0)
                     && (!have_prev_q || (fdat > pf_q) || ((fdat == pf_q) && (rsym_q > ps_q)))
                     && (!found_q || (fdat < bf_q));
  assign a_empty   = (ha_q == na_q);
  assign b_empty   = (hb_q == nb_q);
  assign pick_a    = !a_empty && (b_empty || (WW'(a_rd[FREQ_BITS-1:0]) <= b_rd));
  assign pick_n    = pick_a ? NW'(a_rd[AW-1:FREQ_BITS]) : (SYM_N + NW'(hb_q[IW-1:0]));
  assign pick_w    = pick_a ? WW'(a_rd[FREQ_BITS-1:0]) : b_rd;
  assign cur       = (walk_q < SYM_N) ? root_q : walk_q;
  assign c_ra      = IW'(cur - SYM_N);
  assign root_leaf = (root_q < SYM_N);
  assign child     = byte_q[7] ? c_rd[NW-1:0] : c_rd[2*NW-1:NW];
  assign f_ra      = cnt_q[IW-1:0];
  assign a_wd      = {bs_q, bf_q};
  assign c_wd      = {n1_q, pick_n};
  assign b_wd      = w1_q + pick_w;

  hufd_ram #(.WIDTH(FREQ_BITS), .DEPTH(SYMBOLS)) u_freq (
    .clk_i  (clk_i),
    .we_i   (f_we),
    .waddr_i(item_i.symbol[IW-1:0]),
    .wdata_i(FREQ_BITS'(item_i.frequency)),
    .raddr_i(f_ra),
    .rdata_o(f_rd)
  );

  hufd_ram #(.WIDTH(AW), .DEPTH(SYMBOLS)) u_leafq (
    .clk_i  (clk_i),
    .we_i   (a_we),
    .waddr_i(na_q[IW-1:0]),
    .wdata_i(a_wd),
    .raddr_i(ha_q[IW-1:0]),
    .rdata_o(a_rd)
  );

  hufd_ram #(.WIDTH(WW), .DEPTH(SYMBOLS)) u_nodeq (
    .clk_i  (clk_i),
    .we_i   (b_we),
    .waddr_i(nb_q[IW-1:0]),
    .wdata_i(b_wd),
    .raddr_i(hb_q[IW-1:0]),
    .rdata_o(b_rd)
  );

  hufd_ram #(.WIDTH(2 * NW), .DEPTH(SYMBOLS)) u_child (
    .clk_i  (clk_i),
    .we_i   (c_we),
    .waddr_i(nb_q[IW-1:0]),
    .wdata_i(c_wd),
    .raddr_i(c_ra),
    .rdata_o(c_rd)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hufd_pkg::S_IDLE: begin
        if (accept) begin
          if (item_i.kind == hufd_pkg::KIND_BUILD) begin
            state_d = hufd_pkg::S_SCAN;
          end else if (item_i.kind == hufd_pkg::KIND_DECODE && ready_q
                       && item_i.valid_bits != 4'd0) begin
            state_d = hufd_pkg::S_DEC;
          end
        end
      end
      hufd_pkg::S_SCAN: begin
        if (cnt_q == SYM_C) state_d = hufd_pkg::S_PASS;
      end
      hufd_pkg::S_PASS: begin
        if (found_q) state_d = hufd_pkg::S_SCAN;
        else if (na_q < CW'(2)) state_d = hufd_pkg::S_IDLE;
        else state_d = hufd_pkg::S_MRD;
      end
      hufd_pkg::S_MRD: state_d = hufd_pkg::S_MPICK;
      hufd_pkg::S_MPICK: begin
        if (!second_q || ((CW + 1)'(nb_q) + (CW + 1)'(2) < (CW + 1)'(na_q))) begin
          state_d = hufd_pkg::S_MRD;
        end else begin
          state_d = hufd_pkg::S_IDLE;
        end
      end
      hufd_pkg::S_DEC: begin
        if (bcnt_q == 4'd0) state_d = hufd_pkg::S_IDLE;
        else if (!root_leaf) state_d = hufd_pkg::S_DUSE;
      end
      hufd_pkg::S_DUSE: state_d = hufd_pkg::S_DEC;
      default: state_d = hufd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;  rv_d = 1'b0;  rsym_d = rsym_q;
    have_prev_d = have_prev_q;  pf_d = pf_q;  ps_d = ps_q;
    found_d = found_q;  bf_d = bf_q;  bs_d = bs_q;
    na_d = na_q;  ha_d = ha_q;  nb_d = nb_q;  hb_d = hb_q;
    second_d = second_q;  n1_d = n1_q;  w1_d = w1_q;
    root_d = root_q;  walk_d = walk_q;  ready_d = ready_q;
    byte_d = byte_q;  bcnt_d = bcnt_q;
    pend_v_d = pend_v_q;  pend_s_d = pend_s_q;
    res_v_d = 1'b0;  res_d = res_q;
    fvld_d = fvld_q;
    f_we = 1'b0;  a_we = 1'b0;  b_we = 1'b0;  c_we = 1'b0;
    leaf_hit = 1'b0;  leaf_n = root_q;

    unique case (state_q)
      hufd_pkg::S_IDLE: begin
        if (accept) begin
          case (item_i.kind)
            hufd_pkg::KIND_LOAD: begin
              if (sym_ok) begin
                f_we = 1'b1;
                fvld_d[item_i.symbol[IW-1:0]] = 1'b1;
              end
            end
            hufd_pkg::KIND_BUILD: begin
              cnt_d = '0;  have_prev_d = 1'b0;  found_d = 1'b0;  na_d = '0;
            end
            hufd_pkg::KIND_DECODE: begin
              if (!ready_q) begin
                res_v_d = 1'b1;
                res_d = '{decoded_symbol: 8'd0, status: hufd_pkg::ST_NO_TREE, last: 1'b1};
              end else begin
                byte_d   = item_i.code_byte;
                bcnt_d   = (item_i.valid_bits > hufd_pkg::MAX_BITS) ? hufd_pkg::MAX_BITS
                                                                  : item_i.valid_bits;
                pend_v_d = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      hufd_pkg::S_SCAN: begin
        if (cnt_q != SYM_C) begin
          cnt_d  = cnt_q + CW'(1);
          rv_d   = 1'b1;
          rsym_d = cnt_q[IW-1:0];
        end
        if (cand) begin
          found_d = 1'b1;  bf_d = fdat;  bs_d = rsym_q;
        end
      end
      hufd_pkg::S_PASS: begin
        if (found_q) begin
          a_we = 1'b1;
          if (na_q == '0) root_d = NW'(bs_q);
          na_d = na_q + CW'(1);
          have_prev_d = 1'b1;  pf_d = bf_q;  ps_d = bs_q;
          found_d = 1'b0;  cnt_d = '0;
        end else if (na_q == '0) begin
          ready_d = 1'b0;
          res_v_d = 1'b1;
          res_d = '{decoded_symbol: 8'd0, status: hufd_pkg::ST_BUILD_FAIL, last: 1'b1};
        end else if (na_q == CW'(1)) begin
          ready_d = 1'b1;  walk_d = root_q;
          res_v_d = 1'b1;
          res_d = '{decoded_symbol: 8'd0, status: hufd_pkg::ST_BUILT, last: 1'b1};
        end else begin
          ha_d = '0;  nb_d = '0;  hb_d = '0;  second_d = 1'b0;
        end
      end
      hufd_pkg::S_MRD: ;
      hufd_pkg::S_MPICK: begin
        if (pick_a) ha_d = ha_q + CW'(1);
        else hb_d = hb_q + CW'(1);
        if (!second_q) begin
          n1_d = pick_n;  w1_d = pick_w;  second_d = 1'b1;
        end else begin
          c_we = 1'b1;  b_we = 1'b1;
          nb_d = nb_q + CW'(1);
          second_d = 1'b0;
          if (!((CW + 1)'(nb_q) + (CW + 1)'(2) < (CW + 1)'(na_q))) begin
            root_d  = SYM_N + NW'(nb_q[IW-1:0]);
            walk_d  = SYM_N + NW'(nb_q[IW-1:0]);
            ready_d = 1'b1;
            res_v_d = 1'b1;
            res_d = '{decoded_symbol: 8'd0, status: hufd_pkg::ST_BUILT, last: 1'b1};
          end
        end
      end
      hufd_pkg::S_DEC: begin
        if (bcnt_q == 4'd0) begin
          if (pend_v_q) begin
            res_v_d = 1'b1;
            res_d = '{decoded_symbol: pend_s_q, status: hufd_pkg::ST_SYMBOL, last: 1'b1};
          end
          pend_v_d = 1'b0;
        end else if (root_leaf) begin
          leaf_hit = 1'b1;  leaf_n = root_q;
          byte_d = {byte_q[6:0], 1'b0};  bcnt_d = bcnt_q - 4'd1;
        end
      end
      hufd_pkg::S_DUSE: begin
        if (child < SYM_N) begin
          leaf_hit = 1'b1;  leaf_n = child;  walk_d = root_q;
        end else begin
          walk_d = child;
        end
        byte_d = {byte_q[6:0], 1'b0};  bcnt_d = bcnt_q - 4'd1;
      end
      default: ;
    endcase

    if (leaf_hit) begin
      if (pend_v_q) begin
        res_v_d = 1'b1;
        res_d = '{decoded_symbol: pend_s_q, status: hufd_pkg::ST_SYMBOL, last: 1'b0};
      end
      pend_v_d = 1'b1;
      pend_s_d = 8'(leaf_n);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hufd_pkg::S_IDLE;
      cnt_q       <= '0;
      rv_q        <= 1'b0;
      have_prev_q <= 1'b0;
      found_q     <= 1'b0;
      na_q        <= '0;
      ha_q        <= '0;
      nb_q        <= '0;
      hb_q        <= '0;
      second_q    <= 1'b0;
      root_q      <= '0;
      walk_q      <= '0;
      ready_q     <= 1'b0;
      bcnt_q      <= '0;
      pend_v_q    <= 1'b0;
      res_v_q     <= 1'b0;
      fvld_q      <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rv_q        <= rv_d;
      have_prev_q <= have_prev_d;
      found_q     <= found_d;
      na_q        <= na_d;
      ha_q        <= ha_d;
      nb_q        <= nb_d;
      hb_q        <= hb_d;
      second_q    <= second_d;
      root_q      <= root_d;
      walk_q      <= walk_d;
      ready_q     <= ready_d;
      bcnt_q      <= bcnt_d;
      pend_v_q    <= pend_v_d;
      res_v_q     <= res_v_d;
      fvld_q      <= fvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsym_q   <= rsym_d;
    pf_q     <= pf_d;
    ps_q     <= ps_d;
    bf_q     <= bf_d;
    bs_q     <= bs_d;
    n1_q     <= n1_d;
    w1_q     <= w1_d;
    byte_q   <= byte_d;
    pend_s_q <= pend_s_d;
    res_q    <= res_d;
    fv_q     <= fvld_q[f_ra];
  end

  assign result_valid_o = res_v_q;
  assign result_o       = res_q;

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hufd_pkg::S_IDLE) |-> !pend_v_q)
    else $error("pending symbol left in idle");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.status != hufd_pkg::ST_SYMBOL) |-> result_o.last)
    else $error("status result not flagged last");

  a_merge_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hufd_pkg::S_MPICK) |-> (nb_q < na_q))
    else $error("merge count overran leaf count");

  a_walk_internal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hufd_pkg::S_DUSE) |-> (cur >= SYM_N))
    else $error("child read from a leaf");

endmodule
